// ===== src/bta_pkg.sv =====
// ----------------------------------------------------------------------------
// bta_pkg
// shared codes and sequencer types for the boundary-tag heap allocator
// ----------------------------------------------------------------------------
package bta_pkg;

    localparam logic [1:0] OP_INIT    = 2'd0;
    localparam logic [1:0] OP_ALLOC   = 2'd1;
    localparam logic [1:0] OP_FREE    = 2'd2;
    localparam logic [1:0] OP_REALLOC = 2'd3;

    localparam logic [1:0] ST_PTR     = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_EXHAUST = 2'd2;
    localparam logic [1:0] ST_NOINIT  = 2'd3;

    localparam int unsigned MIN_BLOCK   = 16;
    localparam int unsigned PRO_TAG     = 9;
    localparam int unsigned EPI_TAG     = 1;
    localparam int unsigned FIRST_BP    = 16;
    localparam int unsigned CHUNK_RESET = 1024;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT0,
        S_INIT1,
        S_INIT2,
        S_INIT3,
        S_GROW,
        S_GROW_EPI,
        S_SB_H,
        S_SB_F,
        S_MRG0,
        S_MRG1,
        S_MRG2,
        S_MRG3,
        S_MRG_RET,
        S_WALK,
        S_WALK_CK,
        S_EXTEND,
        S_CARVE,
        S_CARVE_CK,
        S_CARVE2,
        S_CARVE_END,
        S_FREE0,
        S_FREE1,
        S_VAL1,
        S_VAL2,
        S_RPW,
        S_RNW,
        S_RDEC,
        S_RSPLIT2,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        CTX_INIT,
        CTX_ALLOC,
        CTX_FREE
    } t_ctx;

endpackage

// ===== src/bta_tag_ram.sv =====
// ----------------------------------------------------------------------------
// bta_tag_ram
// tag word store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module bta_tag_ram #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14,
    parameter int DATA_W = 17
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/boundary_tag_heap_allocator.sv =====
// a request turned away at once is answered straight from idle; first fit visits the headers
//   one after another until one fits or the walk reaches the epilogue or the break
// throughput: one request at a time; growing the break adds tag writes and a merge, and a moved
//   realloc runs its block check, a full allocation and a free in turn
// reset: synchronous, clears break, heap-ready flag and sets chunk_words to 1024;
//   tag ram is not cleared; results are strobed once and cannot be stalled
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator
// first-fit boundary-tag allocator sequencer over a single tag ram
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_block_addr,
    input  logic [15:0] i_request_size,
    input  logic        i_cfg_we,
    input  logic [14:0] i_cfg_wdata,
    output logic        o_result_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_result_addr,
    output logic [15:0] o_copy_src,
    output logic [15:0] o_copy_dst,
    output logic [16:0] o_copy_len
);

    import bta_pkg::*;

    localparam int AW = ($clog2(HEAP_BYTES) + 2 > 19) ? $clog2(HEAP_BYTES) + 2 : 19;
    localparam int TW = $clog2(HEAP_BYTES) + 1;
    localparam int DEPTH = HEAP_BYTES / 4;
    localparam int WW = $clog2(DEPTH);
    localparam logic [AW-1:0] HEAP_END = AW'(HEAP_BYTES);
    localparam logic [AW-1:0] MINB = AW'(MIN_BLOCK);

    function automatic logic [AW-1:0] tsize(input logic [TW-1:0] t);
        tsize = {{(AW-TW){1'b0}}, t[TW-1:3], 3'b000};
    endfunction

    function automatic logic [AW-1:0] round8(input logic [AW-1:0] x);
        logic [AW-1:0] tmp;
        tmp = x + AW'(7);
        round8 = {tmp[AW-1:3], 3'b000};
    endfunction

    function automatic logic [AW-1:0] block_size(input logic [15:0] req);
        logic [AW-1:0] tmp;
        tmp = AW'(req) + AW'(15);
        block_size = (req <= 16'd8) ? MINB : {tmp[AW-1:3], 3'b000};
    endfunction

    t_state r_state, n_state, r_ret, n_ret;
    t_ctx   r_ctx, n_ctx;
    logic          r_fb, n_fb;
    logic          r_ready, n_ready;
    logic          r_done, n_done;
    logic          r_oob;
    logic [14:0]   r_chunk;
    logic [1:0]    r_op, n_op;
    logic [15:0]   r_ptr, n_ptr;
    logic [15:0]   r_req, n_req;
    logic [AW-1:0] r_brk, n_brk;
    logic [AW-1:0] r_asize, n_asize;
    logic [AW-1:0] r_bp, n_bp;
    logic [AW-1:0] r_gsize, n_gsize;
    logic [AW-1:0] r_cur, n_cur;
    logic [AW-1:0] r_all, n_all;
    logic [AW-1:0] r_left, n_left;
    logic [AW-1:0] r_msize, n_msize;
    logic [TW-1:0] r_w, n_w;
    logic [TW-1:0] r_pw, n_pw;
    logic [TW-1:0] r_nw, n_nw;
    logic [AW-1:0] r_sb_bp, n_sb_bp;
    logic [AW-1:0] r_sb_size, n_sb_size;
    logic          r_sb_alloc, n_sb_alloc;
    logic [1:0]    r_status, n_status;
    logic [15:0]   r_res, n_res;
    logic [15:0]   r_src, n_src;
    logic [15:0]   r_dst, n_dst;
    logic [16:0]   r_len, n_len;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [TW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [TW-1:0] ram_rdata;
    logic [TW-1:0] rdv;
    logic          ram_we;

    assign ram_we = mem_we && (mem_waddr < HEAP_END);
    assign rdv    = r_oob ? '0 : ram_rdata;

    bta_tag_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (WW),
        .DATA_W (TW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (mem_waddr[WW+1:2]),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr[WW+1:2]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
            r_done  <= 1'b0;
            r_brk   <= '0;
            r_chunk <= 15'(CHUNK_RESET);
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
            r_done  <= n_done;
            r_brk   <= n_brk;
            if (i_cfg_we) begin
                r_chunk <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_oob      <= !(mem_raddr < HEAP_END);
        r_ret      <= n_ret;
        r_ctx      <= n_ctx;
        r_fb       <= n_fb;
        r_op       <= n_op;
        r_ptr      <= n_ptr;
        r_req      <= n_req;
        r_asize    <= n_asize;
        r_bp       <= n_bp;
        r_gsize    <= n_gsize;
        r_cur      <= n_cur;
        r_all      <= n_all;
        r_left     <= n_left;
        r_msize    <= n_msize;
        r_w        <= n_w;
        r_pw       <= n_pw;
        r_nw       <= n_nw;
        r_sb_bp    <= n_sb_bp;
        r_sb_size  <= n_sb_size;
        r_sb_alloc <= n_sb_alloc;
        r_status   <= n_status;
        r_res      <= n_res;
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_len      <= n_len;
    end

    always_comb begin
        logic [AW-1:0] ptr_a;
        logic [AW-1:0] cb;
        logic [AW-1:0] ext;
        logic [AW-1:0] sz;
        logic [AW-1:0] msz;
        logic [AW-1:0] mbp;
        logic [AW-1:0] all;
        logic [AW-1:0] bpn;
        logic          pfree;
        logic          nfree;

        ptr_a = AW'(r_ptr);
        cb    = AW'({(r_chunk < 15'd2) ? 15'd2 : r_chunk, 2'b00});
        ext   = (r_asize > cb) ? r_asize : cb;
        sz    = tsize(rdv);
        pfree = !r_pw[0];
        nfree = !r_nw[0];
        all   = r_cur + (pfree ? tsize(r_pw) : '0) + (nfree ? tsize(r_nw) : '0);
        bpn   = pfree ? ptr_a - tsize(r_pw) : ptr_a;
        msz   = r_msize + (!rdv[0] ? sz : '0) + (!r_pw[0] ? tsize(r_pw) : '0);
        mbp   = !r_pw[0] ? r_bp - tsize(r_pw) : r_bp;

        n_state = r_state;  n_ret = r_ret;  n_ctx = r_ctx;  n_fb = r_fb;
        n_ready = r_ready;  n_done = 1'b0;  n_brk = r_brk;
        n_op = r_op;  n_ptr = r_ptr;  n_req = r_req;
        n_asize = r_asize;  n_bp = r_bp;  n_gsize = r_gsize;  n_cur = r_cur;
        n_all = r_all;  n_left = r_left;  n_msize = r_msize;
        n_w = r_w;  n_pw = r_pw;  n_nw = r_nw;
        n_sb_bp = r_sb_bp;  n_sb_size = r_sb_size;  n_sb_alloc = r_sb_alloc;
        n_status = r_status;  n_res = r_res;  n_src = r_src;  n_dst = r_dst;
        n_len = r_len;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op     = i_op;
                    n_ptr    = i_block_addr;
                    n_req    = i_request_size;
                    n_asize  = block_size(i_request_size);
                    n_status = ST_NONE;
                    n_res    = '0;
                    n_src    = '0;
                    n_dst    = '0;
                    n_len    = '0;
                    n_fb     = 1'b0;
                    n_bp     = AW'(FIRST_BP);
                    n_ctx    = CTX_ALLOC;
                    if (i_op == OP_INIT) begin
                        n_state = S_INIT0;
                    end else if (!r_ready) begin
                        n_status = ST_NOINIT;
                        n_done   = 1'b1;
                    end else if (i_op == OP_ALLOC ||
                                 (i_op == OP_REALLOC && i_block_addr == 16'd0)) begin
                        if (i_request_size == 16'd0) begin
                            n_done = 1'b1;
                        end else begin
                            n_state = S_WALK;
                        end
                    end else if (i_block_addr[2:0] != 3'd0 || i_block_addr < 16'(MIN_BLOCK)) begin
                        n_done = 1'b1;
                    end else begin
                        mem_raddr = AW'(i_block_addr) - AW'(4);
                        n_state   = S_VAL1;
                    end
                end
            end
            S_INIT0: begin
                mem_we = 1'b1;  mem_waddr = AW'(0);  mem_wdata = '0;
                n_state = S_INIT1;
            end
            S_INIT1: begin
                mem_we = 1'b1;  mem_waddr = AW'(4);  mem_wdata = TW'(PRO_TAG);
                n_state = S_INIT2;
            end
            S_INIT2: begin
                mem_we = 1'b1;  mem_waddr = AW'(8);  mem_wdata = TW'(PRO_TAG);
                n_state = S_INIT3;
            end
            S_INIT3: begin
                mem_we = 1'b1;  mem_waddr = AW'(12);  mem_wdata = TW'(EPI_TAG);
                n_brk   = AW'(FIRST_BP);
                n_ready = 1'b1;
                n_gsize = round8(cb);
                n_ctx   = CTX_INIT;
                n_state = S_GROW;
            end
            S_GROW: begin
                if (r_brk + r_gsize > HEAP_END) begin
                    n_status = ST_EXHAUST;
                    n_res    = '0;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_bp       = r_brk;
                    n_brk      = r_brk + r_gsize;
                    n_sb_bp    = r_brk;
                    n_sb_size  = r_gsize;
                    n_sb_alloc = 1'b0;
                    n_ret      = S_GROW_EPI;
                    n_state    = S_SB_H;
                end
            end
            S_GROW_EPI: begin
                // new epilogue just below the break
                mem_we    = 1'b1;
                mem_waddr = r_bp + r_gsize - AW'(4);
                mem_wdata = TW'(EPI_TAG);
                n_state   = S_MRG0;
            end
            S_SB_H: begin
                mem_we    = 1'b1;
                mem_waddr = r_sb_bp - AW'(4);
                mem_wdata = r_sb_size[TW-1:0] | TW'(r_sb_alloc);
                n_state   = S_SB_F;
            end
            S_SB_F: begin
                mem_we    = 1'b1;
                mem_waddr = r_sb_bp + r_sb_size - AW'(8);
                mem_wdata = r_sb_size[TW-1:0] | TW'(r_sb_alloc);
                n_state   = r_ret;
            end
            S_MRG0: begin
                mem_raddr = r_bp - AW'(8);
                n_state   = S_MRG1;
            end
            S_MRG1: begin
                n_pw      = rdv;
                mem_raddr = r_bp - AW'(4);
                n_state   = S_MRG2;
            end
            S_MRG2: begin
                n_msize   = sz;
                mem_raddr = r_bp + sz - AW'(4);
                n_state   = S_MRG3;
            end
            S_MRG3: begin
                if (r_pw[0] && rdv[0]) begin
                    n_state = S_MRG_RET;
                end else begin
                    n_bp       = mbp;
                    n_sb_bp    = mbp;
                    n_sb_size  = msz;
                    n_sb_alloc = 1'b0;
                    n_ret      = S_MRG_RET;
                    n_state    = S_SB_H;
                end
            end
            S_MRG_RET: begin
                case (r_ctx)
                    CTX_ALLOC: begin
                        n_state = S_CARVE;
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_WALK: begin
                if (r_bp < r_brk) begin
                    mem_raddr = r_bp - AW'(4);
                    n_state   = S_WALK_CK;
                end else begin
                    n_state = S_EXTEND;
                end
            end
            S_WALK_CK: begin
                // epilogue or a zero size ends the walk
                if (rdv == TW'(EPI_TAG) || sz == '0) begin
                    n_state = S_EXTEND;
                end else if (!rdv[0] && sz >= r_asize) begin
                    n_state = S_CARVE;
                end else begin
                    n_bp    = r_bp + sz;
                    n_state = S_WALK;
                end
            end
            S_EXTEND: begin
                n_gsize = round8(ext);
                n_ctx   = CTX_ALLOC;
                n_state = S_GROW;
            end
            S_CARVE: begin
                mem_raddr = r_bp - AW'(4);
                n_state   = S_CARVE_CK;
            end
            S_CARVE_CK: begin
                n_sb_bp    = r_bp;
                n_sb_alloc = 1'b1;
                n_left     = sz - r_asize;
                n_state    = S_SB_H;
                if (sz - r_asize >= MINB) begin
                    n_sb_size = r_asize;
                    n_ret     = S_CARVE2;
                end else begin
                    n_sb_size = sz;
                    n_ret     = S_CARVE_END;
                end
            end
            S_CARVE2: begin
                n_sb_bp    = r_bp + r_asize;
                n_sb_size  = r_left;
                n_sb_alloc = 1'b0;
                n_ret      = S_CARVE_END;
                n_state    = S_SB_H;
            end
            S_CARVE_END: begin
                n_status = ST_PTR;
                n_res    = r_bp[15:0];
                if (r_fb) begin
                    // moved realloc: report the copy, then release the old block
                    n_src   = r_ptr;
                    n_dst   = r_bp[15:0];
                    n_len   = 17'(r_cur - AW'(8));
                    n_state = S_FREE0;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FREE0: begin
                mem_raddr = ptr_a - AW'(4);
                n_state   = S_FREE1;
            end
            S_FREE1: begin
                n_bp       = ptr_a;
                n_sb_bp    = ptr_a;
                n_sb_size  = sz;
                n_sb_alloc = 1'b0;
                n_ctx      = CTX_FREE;
                n_ret      = S_MRG0;
                n_state    = S_SB_H;
            end
            S_VAL1: begin
                if (!rdv[0] || sz < MINB || ptr_a + sz > r_brk) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_w       = rdv;
                    n_cur     = sz;
                    mem_raddr = ptr_a + sz - AW'(8);
                    n_state   = S_VAL2;
                end
            end
            S_VAL2: begin
                if (rdv != r_w) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_op == OP_FREE || r_req == 16'd0) begin
                    n_state = S_FREE0;
                end else begin
                    mem_raddr = ptr_a - AW'(8);
                    n_state   = S_RPW;
                end
            end
            S_RPW: begin
                n_pw      = rdv;
                mem_raddr = ptr_a + r_cur - AW'(4);
                n_state   = S_RNW;
            end
            S_RNW: begin
                n_nw    = rdv;
                n_state = S_RDEC;
            end
            S_RDEC: begin
                n_all      = all;
                n_status   = ST_PTR;
                n_res      = r_ptr;
                n_bp       = bpn;
                n_sb_bp    = bpn;
                n_sb_alloc = 1'b1;
                n_sb_size  = r_asize;
                n_ret      = S_RSPLIT2;
                if (r_cur == r_asize) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_cur > r_asize) begin
                    if (bpn == ptr_a && !nfree && r_cur - r_asize < MINB) begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        if (bpn != ptr_a) begin
                            n_src = r_ptr;
                            n_dst = bpn[15:0];
                            n_len = 17'(r_asize - AW'(8));
                        end
                        n_res   = bpn[15:0];
                        n_state = S_SB_H;
                    end
                end else if (all < r_asize) begin
                    // no room in place: fall back to a fresh allocation
                    n_fb     = 1'b1;
                    n_status = ST_NONE;
                    n_res    = '0;
                    n_bp     = AW'(FIRST_BP);
                    n_ctx    = CTX_ALLOC;
                    n_state  = S_WALK;
                end else begin
                    if (bpn != ptr_a) begin
                        n_src = r_ptr;
                        n_dst = bpn[15:0];
                        n_len = 17'(r_cur - AW'(8));
                    end
                    n_res   = bpn[15:0];
                    n_state = S_SB_H;
                    if (all - r_asize < MINB) begin
                        n_sb_size = all;
                        n_ret     = S_FIN;
                    end
                end
            end
            S_RSPLIT2: begin
                n_sb_bp    = r_bp + r_asize;
                n_sb_size  = r_all - r_asize;
                n_sb_alloc = 1'b0;
                n_ret      = S_FIN;
                n_state    = S_SB_H;
            end
            S_FIN: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_done;
    assign o_status       = r_status;
    assign o_result_addr  = r_res;
    assign o_copy_src     = r_src;
    assign o_copy_dst     = r_dst;
    assign o_copy_len     = r_len;

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("tag write while idle");

    // a request turned away at once answers straight from idle
    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(start || r_state != S_IDLE))
        else $error("result strobe without a request in progress");

    a_brk_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_brk <= HEAP_END)
        else $error("break beyond heap");

    a_start_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && r_state == S_IDLE) |=> (r_state != S_IDLE || r_done))
        else $error("request dropped");

endmodule
